// ===== hdl/mic_pkg.sv =====
// Shared types and constants for the magnetometer iron calibration block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package mic_pkg;

	// Coefficient and output format
	localparam int COEF_FRAC_BITS = 14;
	localparam int OUT_WIDTH      = 24;
	localparam int COEF_W         = 16;

	// Sensor count and offset widths
	localparam int RAW_W = 20;
	localparam int OFS_W = 21;

	// Configuration register widths and port widths
	localparam int HI_W   = 3 * OFS_W;
	localparam int ROW_W  = 3 * COEF_W;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int IDX_W  = 3;

	// Datapath widths of one dot product
	localparam int PROD_W = COEF_W + OUT_WIDTH;
	localparam int ACC_W  = PROD_W + 2;

	// Register indexes, one per 8-byte slot
	typedef enum logic [IDX_W-1:0] {
		REG_OFFSETS   = 3'd0,
		REG_SOFT_X    = 3'd1,
		REG_SOFT_Y    = 3'd2,
		REG_SOFT_Z    = 3'd3,
		REG_ROT_X     = 3'd4,
		REG_ROT_Y     = 3'd5,
		REG_ROT_Z     = 3'd6
	} reg_idx_t;

	typedef logic [ROW_W-1:0] row_t;
	typedef row_t [2:0] rows_t;
	typedef logic signed [OUT_WIDTH-1:0] samp_t;
	typedef samp_t [2:0] vec_t;
	typedef logic [RAW_W-1:0] raw_t;
	typedef raw_t [2:0] raw_vec_t;

	// Calibration settings seen by the datapath
	typedef struct packed {
		logic [HI_W-1:0] offsets;
		rows_t           soft_rows;
		rows_t           rot;
	} cfg_t;

	// Input request payload
	typedef struct packed {
		logic [7:0] x_high_byte;
		logic [7:0] x_mid_byte;
		logic [7:0] y_high_byte;
		logic [7:0] y_mid_byte;
		logic [7:0] z_high_byte;
		logic [7:0] z_mid_byte;
		logic [7:0] x_low_byte;
		logic [7:0] y_low_byte;
		logic [7:0] z_low_byte;
		logic       apply_rotation;
	} in_t;

	// Result request payload
	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] final_x;
		logic signed [OUT_WIDTH-1:0] final_y;
		logic signed [OUT_WIDTH-1:0] final_z;
		logic signed [OUT_WIDTH-1:0] unrotated_x;
		logic signed [OUT_WIDTH-1:0] unrotated_y;
		logic signed [OUT_WIDTH-1:0] unrotated_z;
		logic [RAW_W-1:0]            raw_x;
		logic [RAW_W-1:0]            raw_y;
		logic [RAW_W-1:0]            raw_z;
	} out_t;

endpackage
`default_nettype wire

// ===== hdl/magnetometer_iron_calibration_top.sv =====
// Magnetometer hard/soft-iron calibration: top level with pipeline and lanes.
// Depends on mic_pkg, mic_cfg, mic_front and mic_lane.
//
// Accepts one magnetometer sample per clock while the output side keeps up and
// returns one result per sample. Each result passes through the stages in order
// and leaves when the output side is ready. Every stage advances whenever the
// stage after it does, so requests can follow back to back. The five stages are
// count assembly and offset removal, soft-iron products in three row lanes,
// soft-iron sum and saturation, rotation products in three more lanes, and the
// rotation sum with the final select into the output register. Stages that
// hold no sample keep taking requests while a result waits at the output, so
// the input stalls only once all five stages are full.
// Configuration registers sit at byte address 8*index on the APB-style port and
// must be written while no sample is in flight.
`default_nettype none
module magnetometer_iron_calibration_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mic_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mic_pkg::DATA_W-1:0]  pwdata,
	output logic      [mic_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire mic_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output mic_pkg::out_t                    out_data
);

	mic_pkg::cfg_t     cfg;
	mic_pkg::raw_vec_t raw_c;
	mic_pkg::vec_t     corr_c;
	mic_pkg::vec_t     unrot_c;
	mic_pkg::vec_t     rot_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	mic_pkg::raw_vec_t raw_s1, raw_s2, raw_s3, raw_s4;
	mic_pkg::vec_t     corr_s1;
	mic_pkg::vec_t     unrot_s3, unrot_s4;
	logic              rot_s1, rot_s2, rot_s3, rot_s4;
	mic_pkg::out_t     out_s5;

	mic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mic_front u_front (
		.in_data (in_data),
		.offsets (cfg.offsets),
		.raw     (raw_c),
		.corr    (corr_c)
	);

	// Advance a stage when it is empty or the stage after it advances
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Soft-iron and rotation lanes, one per output row
	for (genvar r = 0; r < 3; r++) begin : g_lane
		mic_lane u_soft (
			.clk (clk),
			.en  (en2),
			.row (cfg.soft_rows[r]),
			.vec (corr_s1),
			.res (unrot_c[r])
		);
		mic_lane u_rot (
			.clk (clk),
			.en  (en4),
			.row (cfg.rot[r]),
			.vec (unrot_s3),
			.res (rot_c[r])
		);
	end

	// Carry sample data alongside the lanes
	always_ff @(posedge clk) begin
		if (en1) begin
			raw_s1  <= raw_c;
			corr_s1 <= corr_c;
			rot_s1  <= in_data.apply_rotation;
		end
		if (en2) begin
			raw_s2 <= raw_s1;
			rot_s2 <= rot_s1;
		end
		if (en3) begin
			raw_s3   <= raw_s2;
			rot_s3   <= rot_s2;
			unrot_s3 <= unrot_c;
		end
		if (en4) begin
			raw_s4   <= raw_s3;
			rot_s4   <= rot_s3;
			unrot_s4 <= unrot_s3;
		end
		if (en5) begin
			out_s5.final_x     <= rot_s4 ? rot_c[0] : unrot_s4[0];
			out_s5.final_y     <= rot_s4 ? rot_c[1] : unrot_s4[1];
			out_s5.final_z     <= rot_s4 ? rot_c[2] : unrot_s4[2];
			out_s5.unrotated_x <= unrot_s4[0];
			out_s5.unrotated_y <= unrot_s4[1];
			out_s5.unrotated_z <= unrot_s4[2];
			out_s5.raw_x       <= raw_s4[0];
			out_s5.raw_y       <= raw_s4[1];
			out_s5.raw_z       <= raw_s4[2];
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule
`default_nettype wire

// ===== hdl/mic_cfg.sv =====
// Configuration register file with an APB-style write and read port.
// Depends on mic_pkg for register indexes, widths and the cfg_t bundle.
`default_nettype none
module mic_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mic_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mic_pkg::DATA_W-1:0]  pwdata,
	output logic      [mic_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output mic_pkg::cfg_t                    cfg
);

	localparam mic_pkg::row_t ID_X = mic_pkg::row_t'(1) << mic_pkg::COEF_FRAC_BITS;
	localparam mic_pkg::row_t ID_Y = ID_X << mic_pkg::COEF_W;
	localparam mic_pkg::row_t ID_Z = ID_Y << mic_pkg::COEF_W;

	logic [mic_pkg::HI_W-1:0] offsets_q;
	mic_pkg::rows_t           soft_q;
	mic_pkg::rows_t           rot_q;
	mic_pkg::reg_idx_t        idx;
	logic                     wr_en;

	assign idx    = mic_pkg::reg_idx_t'(paddr[mic_pkg::ADDR_W-1:mic_pkg::ADDR_W-mic_pkg::IDX_W]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offsets_q <= '0;
			soft_q    <= {ID_Z, ID_Y, ID_X};
			rot_q     <= {ID_Z, ID_Y, ID_X};
		end else if (wr_en) begin
			case (idx)
				mic_pkg::REG_OFFSETS:   offsets_q <= pwdata[mic_pkg::HI_W-1:0];
				mic_pkg::REG_SOFT_X:    soft_q[0] <= pwdata[mic_pkg::ROW_W-1:0];
				mic_pkg::REG_SOFT_Y:    soft_q[1] <= pwdata[mic_pkg::ROW_W-1:0];
				mic_pkg::REG_SOFT_Z:    soft_q[2] <= pwdata[mic_pkg::ROW_W-1:0];
				mic_pkg::REG_ROT_X:     rot_q[0]  <= pwdata[mic_pkg::ROW_W-1:0];
				mic_pkg::REG_ROT_Y:     rot_q[1]  <= pwdata[mic_pkg::ROW_W-1:0];
				mic_pkg::REG_ROT_Z:     rot_q[2]  <= pwdata[mic_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero-extended
	always_comb begin
		case (idx)
			mic_pkg::REG_OFFSETS:   prdata = mic_pkg::DATA_W'(offsets_q);
			mic_pkg::REG_SOFT_X:    prdata = mic_pkg::DATA_W'(soft_q[0]);
			mic_pkg::REG_SOFT_Y:    prdata = mic_pkg::DATA_W'(soft_q[1]);
			mic_pkg::REG_SOFT_Z:    prdata = mic_pkg::DATA_W'(soft_q[2]);
			mic_pkg::REG_ROT_X:     prdata = mic_pkg::DATA_W'(rot_q[0]);
			mic_pkg::REG_ROT_Y:     prdata = mic_pkg::DATA_W'(rot_q[1]);
			mic_pkg::REG_ROT_Z:     prdata = mic_pkg::DATA_W'(rot_q[2]);
			default:                prdata = '0;
		endcase
	end

	assign cfg.offsets   = offsets_q;
	assign cfg.soft_rows = soft_q;
	assign cfg.rot       = rot_q;

endmodule
`default_nettype wire

// ===== hdl/mic_front.sv =====
// Count assembly and hard-iron offset removal for all three axes.
// Depends on mic_pkg for the input payload and vector types.
`default_nettype none
module mic_front (
	input  wire mic_pkg::in_t               in_data,
	input  wire logic [mic_pkg::HI_W-1:0]   offsets,
	output mic_pkg::raw_vec_t               raw,
	output mic_pkg::vec_t                   corr
);

	logic [2:0][7:0] hi_b;
	logic [2:0][7:0] mid_b;
	logic [2:0][7:0] lo_b;

	assign hi_b  = {in_data.z_high_byte, in_data.y_high_byte, in_data.x_high_byte};
	assign mid_b = {in_data.z_mid_byte, in_data.y_mid_byte, in_data.x_mid_byte};
	assign lo_b  = {in_data.z_low_byte, in_data.y_low_byte, in_data.x_low_byte};

	// Build each count from two bytes and a nibble, then subtract its offset
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw[i]  = {hi_b[i], mid_b[i], lo_b[i][7:4]};
			corr[i] = mic_pkg::OUT_WIDTH'($signed({1'b0, raw[i]}))
				- mic_pkg::OUT_WIDTH'($signed(offsets[i*mic_pkg::OFS_W +: mic_pkg::OFS_W]));
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mic_lane.sv =====
// One matrix row times a vector: registered products, then round and saturate.
// Depends on mic_pkg for coefficient, product and output widths.
`default_nettype none
module mic_lane (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire mic_pkg::row_t row,
	input  wire mic_pkg::vec_t vec,
	output mic_pkg::samp_t     res
);

	localparam int PW = mic_pkg::PROD_W;
	localparam int AW = mic_pkg::ACC_W;
	localparam int OW = mic_pkg::OUT_WIDTH;
	localparam logic signed [AW-1:0] HALF = AW'(2 ** (mic_pkg::COEF_FRAC_BITS - 1));

	logic signed [PW-1:0] prod_s1 [3];
	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] q;
	logic [AW-OW:0]       top;

	// Multiply each coefficient with its element
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				prod_s1[c] <= PW'($signed(row[c*mic_pkg::COEF_W +: mic_pkg::COEF_W]))
					* PW'($signed(vec[c]));
		end
	end

	// Sum, round half up, and clamp to the output range
	always_comb begin
		acc = AW'(prod_s1[0]) + AW'(prod_s1[1]) + AW'(prod_s1[2]) + HALF;
		q   = acc >>> mic_pkg::COEF_FRAC_BITS;
		top = q[AW-1:OW-1];
		if ((&top) || !(|top))
			res = q[OW-1:0];
		else if (q[AW-1])
			res = {1'b1, {(OW-1){1'b0}}};
		else
			res = {1'b0, {(OW-1){1'b1}}};
	end

endmodule
`default_nettype wire

// ===== sim/mic_calib_checker.sv =====
// Scoreboard for the magnetometer iron calibration block: tracks the register
// writes, works out each result from the accepted sample and compares it.
// Depends on mic_pkg.
import mic_pkg::*;

module mic_calib_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  in_t               in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  out_t              out_data,
	output int                fail_count,
	output int                pending,
	output int                checked
);

	localparam longint SAT_HI   = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
	localparam longint SAT_LO   = -SAT_HI - 1;
	localparam longint HALF_LSB = longint'(1) <<< (COEF_FRAC_BITS - 1);

	// Local copy of the calibration settings
	logic [HI_W-1:0] offsets_q;
	rows_t           soft_q;
	rows_t           rot_q;

	// Results still owed by the block, oldest first
	out_t calib_q[$];
	out_t expd_r;
	int   errs = 0;
	int   n_checked = 0;

	// One matrix row: exact dot product, round half up, clamp to output range
	function automatic longint row_apply(row_t row, longint a, longint b, longint c);
		logic signed [COEF_W-1:0] k0, k1, k2;
		longint acc, q;
		k0 = row[COEF_W-1:0];
		k1 = row[2*COEF_W-1:COEF_W];
		k2 = row[3*COEF_W-1:2*COEF_W];
		acc = longint'(k0) * a + longint'(k1) * b + longint'(k2) * c;
		q = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return q;
	endfunction

	// Full correction of one sample under the current settings
	function automatic out_t calibrate(in_t s);
		raw_t                    rx, ry, rz;
		logic signed [OFS_W-1:0] ox, oy, oz;
		longint                  cx, cy, cz, ux, uy, uz;
		out_t                    r;
		rx = {s.x_high_byte, s.x_mid_byte, s.x_low_byte[7:4]};
		ry = {s.y_high_byte, s.y_mid_byte, s.y_low_byte[7:4]};
		rz = {s.z_high_byte, s.z_mid_byte, s.z_low_byte[7:4]};
		ox = offsets_q[OFS_W-1:0];
		oy = offsets_q[2*OFS_W-1:OFS_W];
		oz = offsets_q[3*OFS_W-1:2*OFS_W];
		cx = longint'(rx) - longint'(ox);
		cy = longint'(ry) - longint'(oy);
		cz = longint'(rz) - longint'(oz);
		ux = row_apply(soft_q[0], cx, cy, cz);
		uy = row_apply(soft_q[1], cx, cy, cz);
		uz = row_apply(soft_q[2], cx, cy, cz);
		r.unrotated_x = OUT_WIDTH'(ux);
		r.unrotated_y = OUT_WIDTH'(uy);
		r.unrotated_z = OUT_WIDTH'(uz);
		// rotation works on the clamped vector that is also reported
		if (s.apply_rotation) begin
			r.final_x = OUT_WIDTH'(row_apply(rot_q[0], ux, uy, uz));
			r.final_y = OUT_WIDTH'(row_apply(rot_q[1], ux, uy, uz));
			r.final_z = OUT_WIDTH'(row_apply(rot_q[2], ux, uy, uz));
		end else begin
			r.final_x = r.unrotated_x;
			r.final_y = r.unrotated_y;
			r.final_z = r.unrotated_z;
		end
		r.raw_x = rx;
		r.raw_y = ry;
		r.raw_z = rz;
		return r;
	endfunction

	task automatic check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			errs++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity matrices, no offsets
			offsets_q = '0;
			soft_q = '0;
			rot_q = '0;
			for (int r = 0; r < 3; r++) begin
				soft_q[r][COEF_W*r +: COEF_W] = COEF_W'(1 << COEF_FRAC_BITS);
				rot_q[r][COEF_W*r +: COEF_W] = COEF_W'(1 << COEF_FRAC_BITS);
			end
			calib_q.delete();
		end else begin
			// follow register writes; unused slots and excess bits drop out
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_OFFSETS:   offsets_q = pwdata[HI_W-1:0];
					REG_SOFT_X:    soft_q[0] = pwdata[ROW_W-1:0];
					REG_SOFT_Y:    soft_q[1] = pwdata[ROW_W-1:0];
					REG_SOFT_Z:    soft_q[2] = pwdata[ROW_W-1:0];
					REG_ROT_X:     rot_q[0] = pwdata[ROW_W-1:0];
					REG_ROT_Y:     rot_q[1] = pwdata[ROW_W-1:0];
					REG_ROT_Z:     rot_q[2] = pwdata[ROW_W-1:0];
					default:       ;
				endcase
			end

			// compare the delivered result against the oldest prediction
			if (out_valid && out_ready) begin
				if (calib_q.size() == 0) begin
					errs++;
					$error("result with no sample outstanding: %p", out_data);
				end else begin
					expd_r = calib_q.pop_front();
					check_field("final_x", expd_r.final_x, out_data.final_x);
					check_field("final_y", expd_r.final_y, out_data.final_y);
					check_field("final_z", expd_r.final_z, out_data.final_z);
					check_field("unrotated_x", expd_r.unrotated_x, out_data.unrotated_x);
					check_field("unrotated_y", expd_r.unrotated_y, out_data.unrotated_y);
					check_field("unrotated_z", expd_r.unrotated_z, out_data.unrotated_z);
					check_field("raw_x", expd_r.raw_x, out_data.raw_x);
					check_field("raw_y", expd_r.raw_y, out_data.raw_y);
					check_field("raw_z", expd_r.raw_z, out_data.raw_z);
					n_checked++;
				end
			end

			// predict for the sample taken at this edge
			if (in_valid && in_ready) begin
				calib_q.push_back(calibrate(in_data));
			end

			fail_count <= errs;
			pending <= calib_q.size();
			checked <= n_checked;
		end
	end

endmodule

// ===== sim/tb_magnetometer_iron_calibration_top.sv =====
// Testbench top for magnetometer_iron_calibration_top: drives register writes
// and sample requests through several calibration settings, gives the verdict.
// Depends on mic_pkg and mic_calib_checker.
import mic_pkg::*;

module tb_magnetometer_iron_calibration_top;

	localparam int               HOLD_OFF_CYCLES = 48;
	localparam int               LIMIT_CYCLES    = 200000;
	localparam logic [IDX_W-1:0] UNUSED_SLOT     = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_t               in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;

	logic hold_off_go = 1'b0;
	int   tx_idle_pct = 14;
	int   rx_idle_pct = 14;
	int   sent = 0;
	int   settings = 0;
	int   fail_count;
	int   pending;
	int   checked;

	always #5 clk = ~clk;

	magnetometer_iron_calibration_top dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data
	);

	mic_calib_checker calib_chk (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.fail_count, .pending, .checked
	);

	// Sensor count biased toward the ends of the range and midscale
	function automatic raw_t pick_count();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return raw_t'(20'h80000 + $urandom_range(0, 63) - 32);
			default: return raw_t'($urandom);
		endcase
	endfunction

	function automatic int rand_signed(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	// Split 20-bit counts into the sensor byte layout; junk fills ignored bits
	function automatic in_t make_sample(raw_t x, raw_t y, raw_t z, logic [3:0] junk,
			logic rot);
		in_t s;
		s.x_high_byte = x[19:12];
		s.x_mid_byte = x[11:4];
		s.x_low_byte = {x[3:0], junk};
		s.y_high_byte = y[19:12];
		s.y_mid_byte = y[11:4];
		s.y_low_byte = {y[3:0], ~junk};
		s.z_high_byte = z[19:12];
		s.z_mid_byte = z[11:4];
		s.z_low_byte = {z[3:0], junk};
		s.apply_rotation = rot;
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] coef_row(int c0, int c1, int c2);
		return {16'h0, c2[15:0], c1[15:0], c0[15:0]};
	endfunction

	function automatic logic [DATA_W-1:0] offset_set(int x, int y, int z);
		return {1'b0, z[20:0], y[20:0], x[20:0]};
	endfunction

	// Setup cycle then access cycle; the write lands when pready is seen
	task automatic apb_write(logic [IDX_W-1:0] slot, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({slot, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_all(logic [DATA_W-1:0] hi, logic [DATA_W-1:0] sx,
			logic [DATA_W-1:0] sy, logic [DATA_W-1:0] sz, logic [DATA_W-1:0] rx,
			logic [DATA_W-1:0] ry, logic [DATA_W-1:0] rz);
		apb_write(REG_OFFSETS, hi);
		apb_write(REG_SOFT_X, sx);
		apb_write(REG_SOFT_Y, sy);
		apb_write(REG_SOFT_Z, sz);
		apb_write(REG_ROT_X, rx);
		apb_write(REG_ROT_Y, ry);
		apb_write(REG_ROT_Z, rz);
		settings++;
	endtask

	// Hold the request until taken, then maybe leave a one-cycle gap
	task automatic offer(in_t s);
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been delivered
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			offer(make_sample(pick_count(), pick_count(), pick_count(), 4'($urandom),
				1'($urandom)));
		end
	endtask

	// Range ends and mixed patterns, rotation off then on
	task automatic run_directed();
		raw_t vx[6] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h00001, 20'h12345, 20'h7FFFF};
		raw_t vy[6] = '{20'h00000, 20'hFFFFF, 20'h7FFFF, 20'hFFFFE, 20'hABCDE, 20'h80000};
		raw_t vz[6] = '{20'h00000, 20'hFFFFF, 20'h00001, 20'h80001, 20'h5A5A5, 20'hFFFFF};
		for (int i = 0; i < 12; i++) begin
			offer(make_sample(vx[i % 6], vy[i % 6], vz[i % 6], (i % 2) ? 4'hF : 4'h0,
				i >= 6));
		end
	endtask

	// Output side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		forever begin
			@(posedge clk);
			if (hold_off_go) begin
				out_ready <= 1'b0;
				hold_off_go <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// settings after reset: identity matrices, no offsets
		settings = 1;
		run_directed();
		run_random(50);
		wait_drained();

		// most negative offsets and full-scale coefficients: clamp both ways
		program_all(offset_set(-1048576, -1048576, -1048576),
			coef_row(32767, 32767, 32767), coef_row(32767, 32767, 32767),
			coef_row(32767, 32767, 32767), coef_row(-32768, -32768, -32768),
			coef_row(-32768, -32768, -32768), coef_row(-32768, -32768, -32768));
		run_random(40);
		wait_drained();

		// half-gain rows make exact half-LSB ties; offsets at their limits
		apb_write(UNUSED_SLOT, {$urandom, $urandom});
		program_all(offset_set(1048575, -1048576, 1),
			coef_row(8192, 0, 0), coef_row(0, -8192, 0), coef_row(32767, -32768, 8192),
			coef_row(32767, 0, 0), coef_row(0, -32768, 0), coef_row(4660, -9029, 16384));
		run_directed();
		run_random(60);
		wait_drained();

		// fully random register words, excess bits set too; no idling here
		program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		apb_write(UNUSED_SLOT, {$urandom, $urandom});
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(100);
		wait_drained();
		tx_idle_pct = 14;
		rx_idle_pct = 14;

		// realistic calibration: small offsets, near-identity soft iron
		program_all(offset_set(rand_signed(4096), rand_signed(4096), rand_signed(4096)),
			coef_row(16384 + rand_signed(2048), rand_signed(1024), rand_signed(1024)),
			coef_row(rand_signed(1024), 16384 + rand_signed(2048), rand_signed(1024)),
			coef_row(rand_signed(1024), rand_signed(1024), 16384 + rand_signed(2048)),
			coef_row(rand_signed(16384), rand_signed(16384), rand_signed(16384)),
			coef_row(rand_signed(16384), rand_signed(16384), rand_signed(16384)),
			coef_row(rand_signed(16384), rand_signed(16384), rand_signed(16384)));
		run_random(30);
		// long output stall while requests keep coming, to back up the pipeline
		hold_off_go <= 1'b1;
		tx_idle_pct = 0;
		run_random(25);
		tx_idle_pct = 14;
		run_random(105);
		wait_drained();

		// all registers cleared
		program_all('0, '0, '0, '0, '0, '0, '0);
		run_random(40);

		wait_drained();
		repeat (12) @(posedge clk);
		$display("Sent %0d samples, %0d results compared, over %0d register settings.",
			sent, checked, settings);
		$display("Covered rotation on and off, clamping, half-LSB ties and a long output stall.");
		if (fail_count == 0) begin
			$display("tb_magnetometer_iron_calibration_top OK");
		end else begin
			$display("tb_magnetometer_iron_calibration_top NOT OK");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin : watchdog
		#(LIMIT_CYCLES * 10);
		$display("tb_magnetometer_iron_calibration_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mic_pkg.sv
hdl/mic_cfg.sv
hdl/mic_front.sv
hdl/mic_lane.sv
hdl/magnetometer_iron_calibration_top.sv
sim/mic_calib_checker.sv
sim/tb_magnetometer_iron_calibration_top.sv
